/* src/bandit_spreading_factor_select_core_macros.svh */
// assertion macros for the spreading factor bandit
// used by bandit_spreading_factor_select_core, no other dependencies
`ifndef BANDIT_SPREADING_FACTOR_SELECT_CORE_MACROS_SVH
`define BANDIT_SPREADING_FACTOR_SELECT_CORE_MACROS_SVH

// same-cycle implication
`define BSFS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bsfs assertion failed");

// next-cycle implication
`define BSFS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bsfs assertion failed");

`endif

/* src/bsfs_pkg.sv */
// shared types and constants of the spreading factor bandit
// no dependencies
`default_nettype none

package bsfs_pkg;

    localparam int SF_W     = 4;
    localparam int REWARD_W = 8;
    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 16;
    localparam int MEAN_W   = 16;

    localparam logic CMD_PULL   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PULL,
        S_UPD_RD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  count;
        logic [MEAN_W-1:0] mean;
    } t_arm_stat;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [SUM_W-1:0]  quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

/* src/bandit_spreading_factor_select_core.sv */
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser command, tdata arm/reward/samples
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata chosen_sf/new_mean
//
// pull: one memory read per arm through the stats memory port
// update: the new mean comes from the 32-step serial divider
// unknown arm on update: no memory write
// reset clears control and the memory valid bits at once, no clearing pass
// a finished word waits in the output register; the next word is taken meanwhile
//
// top level of the spreading factor bandit; depends on bsfs_pkg, bsfs_mem, bsfs_div
`default_nettype none
`include "bandit_spreading_factor_select_core_macros.svh"

module bandit_spreading_factor_select_core
    import bsfs_pkg::*;
#(
    parameter int NUM_ARMS  = 6,
    parameter int LOWEST_SF = 7,
    parameter int SCALE     = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // arm, reward, sample_0 .. sample_5
    input  wire logic [71:0] s_axis_tdata,
    // command
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // chosen_sf, new_mean, zero fill
    output logic [23:0]      m_axis_tdata
);

    localparam int AW      = $clog2(NUM_ARMS);
    localparam int SMP_LSB = SF_W + REWARD_W;
    localparam int IDX_W   = 5;
    localparam int ADD_W   = SUM_W + 1;
    localparam logic [AW-1:0] K_LAST = AW'(NUM_ARMS - 1);

    t_state r_state, n_state;

    logic [SF_W-1:0]     r_arm;
    logic                r_arm_ok;
    logic [ADD_W-1:0]    r_radd;
    logic [SAMPLE_W-1:0] r_samples [NUM_ARMS];
    logic [AW-1:0]       r_k;
    logic [MEAN_W-1:0]   r_top;
    logic [SF_W-1:0]     r_best;
    logic [SUM_W-1:0]    r_sum;
    logic [CNT_W-1:0]    r_count;
    logic [SF_W-1:0]     r_res_sf;
    logic [MEAN_W-1:0]   r_res_mean;
    logic                r_out_valid;
    logic [SF_W-1:0]     r_out_sf;
    logic [MEAN_W-1:0]   r_out_mean;

    logic [SF_W-1:0]     w_in_arm;
    logic [REWARD_W-1:0] w_in_reward;
    logic                w_in_acc;
    logic                w_arm_ok;
    logic [AW-1:0]       w_in_idx;
    logic [AW-1:0]       w_raddr;
    logic                w_we;
    logic                w_out_free;
    logic                w_div_start;
    t_arm_stat           w_rd;
    t_arm_stat           w_wdata;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    logic [MEAN_W-1:0]   w_top_cur;
    logic                w_win;
    logic [MEAN_W-1:0]   w_top_next;
    logic [SF_W-1:0]     w_best_next;
    logic [ADD_W-1:0]    w_sum_wide;
    logic [SUM_W-1:0]    w_sum_sat;
    logic [CNT_W-1:0]    w_cnt_inc;
    logic [MEAN_W-1:0]   w_mean_sat;

    assign w_in_arm    = s_axis_tdata[SF_W-1:0];
    assign w_in_reward = s_axis_tdata[SF_W +: REWARD_W];
    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_arm_ok    = ({1'b0, w_in_arm} >= IDX_W'(LOWEST_SF))
                      && ({1'b0, w_in_arm} < IDX_W'(LOWEST_SF + NUM_ARMS));
    assign w_in_idx    = AW'({1'b0, w_in_arm} - IDX_W'(LOWEST_SF));
    assign w_out_free  = !r_out_valid || m_axis_tready;

    // pull scan
    assign w_top_cur   = (r_k == '0) ? w_rd.mean : r_top;
    assign w_win       = (w_rd.mean > w_top_cur)
                      && ({{(MEAN_W - SAMPLE_W){1'b0}}, r_samples[r_k]} > w_top_cur);
    assign w_top_next  = w_win ? w_rd.mean : w_top_cur;
    assign w_best_next = w_win ? SF_W'(LOWEST_SF + int'(r_k)) : r_best;

    // update arithmetic
    assign w_sum_wide  = {1'b0, w_rd.sum} + r_radd;
    assign w_sum_sat   = w_sum_wide[SUM_W] ? '1 : w_sum_wide[SUM_W-1:0];
    assign w_cnt_inc   = (w_rd.count == '1) ? w_rd.count : w_rd.count + 1'b1;
    assign w_mean_sat  = (w_div_rsp.quotient[SUM_W-1:MEAN_W] != '0)
                       ? '1 : w_div_rsp.quotient[MEAN_W-1:0];

    assign w_div_req = '{start: w_div_start, dividend: w_sum_sat, divisor: w_cnt_inc};
    assign w_wdata = '{sum: r_sum, count: r_count, mean: w_mean_sat};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == CMD_UPDATE) begin
                        n_state = w_arm_ok ? S_UPD_RD : S_DONE;
                    end else begin
                        n_state = S_PULL;
                    end
                end
            end
            S_PULL: begin
                if (r_k == K_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_UPD_RD: n_state = S_DIV;
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_raddr       = '0;
        w_we          = 1'b0;
        w_div_start   = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                w_raddr = (s_axis_tuser == CMD_UPDATE && w_arm_ok) ? w_in_idx : '0;
            end
            S_PULL:   w_raddr = (r_k == K_LAST) ? '0 : r_k + 1'b1;
            S_UPD_RD: w_div_start = 1'b1;
            S_DIV:    w_we = w_div_rsp.done;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_arm      <= w_in_arm;
                    r_radd     <= ADD_W'(w_in_reward) * ADD_W'(SCALE);
                    r_best     <= w_in_arm;
                    r_res_sf   <= w_in_arm;
                    r_res_mean <= '0;
                    r_k        <= '0;
                    for (int i = 0; i < NUM_ARMS; i++) begin
                        r_samples[i] <= s_axis_tdata[SMP_LSB + i * SAMPLE_W +: SAMPLE_W];
                    end
                end
            end
            S_PULL: begin
                r_top      <= w_top_next;
                r_best     <= w_best_next;
                r_res_sf   <= w_best_next;
                r_res_mean <= w_top_next;
                r_k        <= r_k + 1'b1;
            end
            S_UPD_RD: begin
                r_sum   <= w_sum_sat;
                r_count <= w_cnt_inc;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    r_res_mean <= w_mean_sat;
                end
            end
            default: begin
                r_res_sf <= r_res_sf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_ok <= 1'b0;
        end else if (w_in_acc) begin
            r_arm_ok <= w_arm_ok && (s_axis_tuser == CMD_UPDATE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_sf   <= r_res_sf;
            r_out_mean <= r_res_mean;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_mean, r_out_sf};

    bsfs_mem #(
        .DEPTH (NUM_ARMS),
        .SCALE (SCALE)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (w_raddr),
        .o_rdata (w_rd),
        .i_we    (w_we),
        .i_waddr (AW'({1'b0, r_arm} - IDX_W'(LOWEST_SF))),
        .i_wdata (w_wdata)
    );

    bsfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    `BSFS_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, w_div_rsp.done, r_state == S_DIV)
    `BSFS_ASSERT_IMP(a_wr_known_arm, i_clk, i_rst_n, w_we, r_arm_ok)
    `BSFS_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, r_state == S_PULL, r_k <= K_LAST)
    `BSFS_ASSERT_NXT(a_acc_leaves_idle, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE)

endmodule

`default_nettype wire

/* src/bsfs_mem.sv */
// per-arm statistics memory, one write and one registered read port
// depends on bsfs_pkg; entries never written read as the reset statistics
`default_nettype none

module bsfs_mem
    import bsfs_pkg::*;
#(
    parameter int DEPTH = 6,
    parameter int SCALE = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [AW-1:0] i_raddr,
    output t_arm_stat          o_rdata,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_arm_stat     i_wdata
);

    localparam t_arm_stat RST_ENTRY = '{sum: '0, count: '0, mean: MEAN_W'(SCALE / 2)};

    t_arm_stat          r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    t_arm_stat          r_rd_data;
    logic               r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : RST_ENTRY;

endmodule

`default_nettype wire

/* src/bsfs_div.sv */
// serial restoring divider, 32-bit dividend by 16-bit divisor, one bit a cycle
// depends on bsfs_pkg
`default_nettype none

module bsfs_div
    import bsfs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int STEP_W = $clog2(SUM_W);

    logic [SUM_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_d;
    logic [CNT_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [CNT_W:0]    w_shift;
    logic              w_ge;
    logic [CNT_W:0]    w_diff;

    assign w_shift = {r_rem, r_q[SUM_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_d};
    assign w_diff  = w_shift - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_d   <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, quotient: r_q};

endmodule

`default_nettype wire
